// ===== rtl/evg_pkg.sv =====
`default_nettype none
package evg_pkg;

  // Frame and field geometry.
  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int SMP_W     = 16;
  localparam int MAG_W     = 16;
  localparam int VAL_W     = 31;
  // A frame holds at most MAX_FRAME squares of at most 2^30 each.
  localparam int SUM_W     = 2 * MAG_W + CNT_W - 2;
  // The weighted noise sum is at most 100 * 2^30.
  localparam int FLOOR_W   = 38;
  localparam int ACC_W     = (SUM_W > FLOOR_W) ? SUM_W : FLOOR_W;
  localparam int ALPHA_W   = 7;
  localparam int RATIO_W   = 4;
  localparam int MUL_W     = MAG_W;
  localparam int DIV_W     = (CNT_W > ALPHA_W) ? CNT_W : ALPHA_W;
  localparam int PCT       = 100;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_ALPHA = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RATIO = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MIN   = IDX_W'(2);

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(10);
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(2);
  localparam logic [VAL_W-1:0]   MIN_RST   = VAL_W'(10000);
  localparam logic [VAL_W-1:0]   NF_RST    = VAL_W'(10000);

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [RATIO_W-1:0] ratio;
    logic [VAL_W-1:0]   min_thr;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] acc_init;
    logic [ACC_W-1:0] mcand;
    logic [MUL_W-1:0] mult;
  } mac_req_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_DIV_GO,
    S_DIV_W,
    S_THR_W,
    S_FA_W,
    S_FB_W,
    S_F100_W,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/evg_ifs.sv =====
`default_nettype none
interface evg_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [evg_pkg::SMP_W-1:0] sample;
  logic                            last_of_frame;
  logic                            learn_noise;

  modport source (output valid, output sample, output last_of_frame,
                  output learn_noise, input ready);
  modport sink (input valid, input sample, input last_of_frame,
                input learn_noise, output ready);
endinterface

interface evg_out_if;
  logic                      valid;
  logic                      ready;
  logic                      is_speech;
  logic [evg_pkg::VAL_W-1:0] frame_energy;
  logic [evg_pkg::VAL_W-1:0] noise_level;
  logic                      frame_overflow;

  modport source (output valid, output is_speech, output frame_energy,
                  output noise_level, output frame_overflow, input ready);
  modport sink (input valid, input is_speech, input frame_energy,
                input noise_level, input frame_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/evg_cfg.sv =====
`default_nettype none
module evg_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [evg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [evg_pkg::DATA_W-1:0] pwdata,
  output      logic [evg_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  output      evg_pkg::cfg_t              cfg
);

  evg_pkg::cfg_t                cfg_r;
  evg_pkg::cfg_t                cfg_nxt;
  logic [evg_pkg::IDX_W-1:0]    idx;

  assign idx    = paddr[evg_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        evg_pkg::REG_ALPHA: cfg_nxt.alpha   = pwdata[evg_pkg::ALPHA_W-1:0];
        evg_pkg::REG_RATIO: cfg_nxt.ratio   = pwdata[evg_pkg::RATIO_W-1:0];
        evg_pkg::REG_MIN:   cfg_nxt.min_thr = pwdata[evg_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      evg_pkg::REG_ALPHA: prdata = evg_pkg::DATA_W'(cfg_r.alpha);
      evg_pkg::REG_RATIO: prdata = evg_pkg::DATA_W'(cfg_r.ratio);
      evg_pkg::REG_MIN:   prdata = evg_pkg::DATA_W'(cfg_r.min_thr);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha   <= evg_pkg::ALPHA_RST;
      cfg_r.ratio   <= evg_pkg::RATIO_RST;
      cfg_r.min_thr <= evg_pkg::MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/evg_mac.sv =====
`default_nettype none
module evg_mac (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire evg_pkg::mac_req_t         req,
  output      logic                      done,
  output      logic [evg_pkg::ACC_W-1:0] acc
);

  localparam int STEP_W = $clog2(evg_pkg::MUL_W);

  logic [evg_pkg::ACC_W-1:0] mcand_r, mcand_nxt;
  logic [evg_pkg::MUL_W-1:0] mult_r, mult_nxt;
  logic [evg_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  assign done = done_r;
  assign acc  = acc_r;

  // Shift-and-add: one multiplier bit per cycle, low bit first.
  always_comb begin
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      mcand_nxt = req.mcand;
      mult_nxt  = req.mult;
      acc_nxt   = req.acc_init;
      step_nxt  = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (mult_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = {mcand_r[evg_pkg::ACC_W-2:0], 1'b0};
      mult_nxt  = {1'b0, mult_r[evg_pkg::MUL_W-1:1]};
      step_nxt  = step_r + STEP_W'(1);
      if (step_r == STEP_W'(evg_pkg::MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    acc_r   <= acc_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/evg_div.sv =====
`default_nettype none
module evg_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire evg_pkg::div_req_t         req,
  output      logic                      done,
  output      logic [evg_pkg::ACC_W-1:0] quot
);

  localparam int STEP_W = $clog2(evg_pkg::ACC_W);

  logic [evg_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [evg_pkg::ACC_W-1:0] quo_r, quo_nxt;
  logic [evg_pkg::DIV_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [evg_pkg::DIV_W:0]   shifted;
  logic [evg_pkg::DIV_W:0]   diff;

  assign done = done_r;
  assign quot = quo_r;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of the quotient register while quotient bits enter below.
  assign shifted = {rem_r, quo_r[evg_pkg::ACC_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[evg_pkg::DIV_W]) begin
        rem_nxt = diff[evg_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[evg_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[evg_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[evg_pkg::ACC_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(evg_pkg::ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/energy_vad_gate_top.sv =====
// Frame energy voice activity gate.
// Samples enter on in_if (valid/ready); the last sample of a frame carries
// last_of_frame, and learn_noise on that sample turns the frame into a noise
// learning frame. One item per frame leaves on out_if (valid/ready) with the
// speech flag, mean energy, current noise floor and the overflow flag.
// Each sample's square is formed by a shift-and-add multiplier that
// retires one bit per cycle over 16 bits, and no new sample is taken
// until it is done. At frame end the mean comes from a restoring divider
// that retires one bit per cycle (41 steps). A decision frame then takes a
// 16-step threshold multiply. A learning frame takes two 16-step multiplies
// and a second 41-step divide by 100. When the last sample itself is
// dropped, its square is skipped. Samples beyond 1024 in one frame are
// dropped and flagged.
// The result sits in an output register; new samples are taken while it
// waits, and only the next frame end stalls until the receiver takes it.
// The user writes configuration through the APB port only while the block is
// idle; the block does not enforce this. Synchronous reset restores register
// defaults, noise floor 10000, and clears the partial frame and output valid.
`default_nettype none
module energy_vad_gate_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  evg_in_if.sink                          in_if,
  evg_out_if.source                       out_if,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [evg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [evg_pkg::DATA_W-1:0] pwdata,
  output      logic [evg_pkg::DATA_W-1:0] prdata,
  output      logic                       pready
);

  evg_pkg::cfg_t     cfg;
  evg_pkg::mac_req_t mac_req;
  evg_pkg::div_req_t div_req;
  logic                      mac_done;
  logic [evg_pkg::ACC_W-1:0] mac_acc;
  logic                      div_done;
  logic [evg_pkg::ACC_W-1:0] div_quot;

  evg_pkg::state_t state_r, state_nxt;

  logic [evg_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [evg_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      last_r, last_nxt;
  logic                      learn_r, learn_nxt;
  logic [evg_pkg::VAL_W-1:0] mean_r, mean_nxt;
  logic [evg_pkg::VAL_W-1:0] nf_r, nf_nxt;
  logic                      speech_r, speech_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_speech_r, out_speech_nxt;
  logic [evg_pkg::VAL_W-1:0] out_energy_r, out_energy_nxt;
  logic [evg_pkg::VAL_W-1:0] out_noise_r, out_noise_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                        accept;
  logic                        room;
  logic                        out_free;
  logic [evg_pkg::MAG_W-1:0]   mag;
  logic [evg_pkg::ALPHA_W-1:0] alpha_sat;
  logic [evg_pkg::ALPHA_W-1:0] beta;

  evg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  evg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  evg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_if.ready = (state_r == evg_pkg::S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign room        = count_r < evg_pkg::CNT_W'(evg_pkg::MAX_FRAME);
  assign out_free    = !out_valid_r || out_if.ready;

  // Two's complement magnitude; the most negative sample maps to 0x8000.
  assign mag = in_if.sample[evg_pkg::SMP_W-1] ?
               (~in_if.sample + evg_pkg::SMP_W'(1)) : in_if.sample;

  assign alpha_sat = (cfg.alpha > evg_pkg::ALPHA_W'(evg_pkg::PCT)) ?
                     evg_pkg::ALPHA_W'(evg_pkg::PCT) : cfg.alpha;
  assign beta      = evg_pkg::ALPHA_W'(evg_pkg::PCT) - alpha_sat;

  assign out_if.valid          = out_valid_r;
  assign out_if.is_speech      = out_speech_r;
  assign out_if.frame_energy   = out_energy_r;
  assign out_if.noise_level    = out_noise_r;
  assign out_if.frame_overflow = out_ovf_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      evg_pkg::S_IDLE: begin
        if (accept) begin
          if (room) begin
            state_nxt = evg_pkg::S_SQ;
          end else if (in_if.last_of_frame) begin
            state_nxt = evg_pkg::S_DIV_GO;
          end
        end
      end
      evg_pkg::S_SQ: begin
        if (mac_done) begin
          state_nxt = last_r ? evg_pkg::S_DIV_GO : evg_pkg::S_IDLE;
        end
      end
      evg_pkg::S_DIV_GO: state_nxt = evg_pkg::S_DIV_W;
      evg_pkg::S_DIV_W: begin
        if (div_done) begin
          state_nxt = learn_r ? evg_pkg::S_FA_W : evg_pkg::S_THR_W;
        end
      end
      evg_pkg::S_THR_W: begin
        if (mac_done) begin
          state_nxt = evg_pkg::S_OUT;
        end
      end
      evg_pkg::S_FA_W: begin
        if (mac_done) begin
          state_nxt = evg_pkg::S_FB_W;
        end
      end
      evg_pkg::S_FB_W: begin
        if (mac_done) begin
          state_nxt = evg_pkg::S_F100_W;
        end
      end
      evg_pkg::S_F100_W: begin
        if (div_done) begin
          state_nxt = evg_pkg::S_OUT;
        end
      end
      evg_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = evg_pkg::S_IDLE;
        end
      end
      default: state_nxt = evg_pkg::S_IDLE;
    endcase
  end

  // Unit requests and datapath updates.
  always_comb begin
    mac_req        = '0;
    div_req        = '0;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    learn_nxt      = learn_r;
    mean_nxt       = mean_r;
    nf_nxt         = nf_r;
    speech_nxt     = speech_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_speech_nxt = out_speech_r;
    out_energy_nxt = out_energy_r;
    out_noise_nxt  = out_noise_r;
    out_ovf_nxt    = out_ovf_r;
    case (state_r)
      evg_pkg::S_IDLE: begin
        if (accept) begin
          last_nxt  = in_if.last_of_frame;
          learn_nxt = in_if.learn_noise;
          if (room) begin
            mac_req.start    = 1'b1;
            mac_req.acc_init = evg_pkg::ACC_W'(sum_r);
            mac_req.mcand    = evg_pkg::ACC_W'(mag);
            mac_req.mult     = mag;
            count_nxt        = count_r + evg_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      evg_pkg::S_SQ: begin
        if (mac_done) begin
          sum_nxt = mac_acc[evg_pkg::SUM_W-1:0];
        end
      end
      evg_pkg::S_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = evg_pkg::ACC_W'(sum_r);
        div_req.divisor  = evg_pkg::DIV_W'(count_r);
      end
      evg_pkg::S_DIV_W: begin
        if (div_done) begin
          mean_nxt      = div_quot[evg_pkg::VAL_W-1:0];
          mac_req.start = 1'b1;
          if (learn_r) begin
            mac_req.mcand = evg_pkg::ACC_W'(div_quot[evg_pkg::VAL_W-1:0]);
            mac_req.mult  = evg_pkg::MUL_W'(alpha_sat);
          end else begin
            mac_req.mcand = evg_pkg::ACC_W'(nf_r);
            mac_req.mult  = evg_pkg::MUL_W'(cfg.ratio);
          end
        end
      end
      evg_pkg::S_THR_W: begin
        if (mac_done) begin
          // Above both the scaled floor and the hard minimum.
          speech_nxt = (evg_pkg::ACC_W'(mean_r) > mac_acc) && (mean_r > cfg.min_thr);
        end
      end
      evg_pkg::S_FA_W: begin
        if (mac_done) begin
          mac_req.start    = 1'b1;
          mac_req.acc_init = mac_acc;
          mac_req.mcand    = evg_pkg::ACC_W'(nf_r);
          mac_req.mult     = evg_pkg::MUL_W'(beta);
        end
      end
      evg_pkg::S_FB_W: begin
        if (mac_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mac_acc;
          div_req.divisor  = evg_pkg::DIV_W'(evg_pkg::PCT);
        end
      end
      evg_pkg::S_F100_W: begin
        if (div_done) begin
          nf_nxt     = div_quot[evg_pkg::VAL_W-1:0];
          speech_nxt = 1'b0;
        end
      end
      evg_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_speech_nxt = speech_r;
          out_energy_nxt = mean_r;
          out_noise_nxt  = nf_r;
          out_ovf_nxt    = ovf_r;
          sum_nxt        = '0;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= evg_pkg::S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      nf_r        <= evg_pkg::NF_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r       <= last_nxt;
    learn_r      <= learn_nxt;
    mean_r       <= mean_nxt;
    speech_r     <= speech_nxt;
    out_speech_r <= out_speech_nxt;
    out_energy_r <= out_energy_nxt;
    out_noise_r  <= out_noise_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

endmodule
`default_nettype wire
